// ===== rtl/pab_pkg.sv =====
// shared types, constants and run-expansion functions for the console bridge
// no dependencies; imported by every rtl module of the bridge except pab_ram
`timescale 1ns / 1ps

package pab_pkg;

   // input byte queue
   localparam int QUEUE_DEPTH = 256;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // run queue between front and back end
   localparam int RUN_FIFO_DEPTH = 4;
   localparam int RF_PTR_W       = $clog2(RUN_FIFO_DEPTH);
   localparam int RF_CNT_W       = $clog2(RUN_FIFO_DEPTH + 1);

   // byte index inside one run, longest run is seven bytes
   localparam int RUN_IDX_W = 3;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_PUSH  = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      RUN_BYTE  = 2'd0,   // one transmit byte
      RUN_CSI   = 2'd1,   // esc [ letter
      RUN_CLEAR = 2'd2,   // esc [2J esc [H
      RUN_READ  = 2'd3    // one byte handed back to the emulator
   } run_type;

   typedef struct packed {
      run_type    run;
      logic [7:0] value;
   } run_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   localparam logic KIND_TX   = 1'b0;
   localparam logic KIND_READ = 1'b1;

   // console codes
   localparam logic [7:0] CODE_CR         = 8'h0D;
   localparam logic [7:0] CODE_LEFT       = 8'd157;
   localparam logic [7:0] CODE_RIGHT      = 8'd29;
   localparam logic [7:0] CODE_UP         = 8'd145;
   localparam logic [7:0] CODE_DOWN       = 8'd17;
   localparam logic [7:0] CODE_HOME       = 8'd19;
   localparam logic [7:0] CODE_CLEAR      = 8'd147;
   localparam logic [7:0] CODE_PRINT_LO   = 8'h20;
   localparam logic [7:0] CODE_PRINT_HI   = 8'h7E;

   // terminal bytes
   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] CHAR_ESC  = 8'h1B;
   localparam logic [7:0] CHAR_LBR  = 8'h5B;  // [
   localparam logic [7:0] CHAR_TWO  = 8'h32;
   localparam logic [7:0] CHAR_J    = 8'h4A;
   localparam logic [7:0] CHAR_A    = 8'h41;
   localparam logic [7:0] CHAR_B    = 8'h42;
   localparam logic [7:0] CHAR_C    = 8'h43;
   localparam logic [7:0] CHAR_D    = 8'h44;
   localparam logic [7:0] CHAR_H    = 8'h48;

   function automatic logic [RUN_IDX_W-1:0] run_last_idx(input run_type run);
      case (run)
         RUN_CSI:   run_last_idx = RUN_IDX_W'(2);
         RUN_CLEAR: run_last_idx = RUN_IDX_W'(6);
         default:   run_last_idx = '0;
      endcase
   endfunction

   function automatic logic [7:0] clear_byte(input logic [RUN_IDX_W-1:0] idx);
      case (idx)
         RUN_IDX_W'(0): clear_byte = CHAR_ESC;
         RUN_IDX_W'(1): clear_byte = CHAR_LBR;
         RUN_IDX_W'(2): clear_byte = CHAR_TWO;
         RUN_IDX_W'(3): clear_byte = CHAR_J;
         RUN_IDX_W'(4): clear_byte = CHAR_ESC;
         RUN_IDX_W'(5): clear_byte = CHAR_LBR;
         default:       clear_byte = CHAR_H;
      endcase
   endfunction

   function automatic logic [7:0] run_byte(input run_type run, input logic [7:0] value,
                                           input logic [RUN_IDX_W-1:0] idx);
      case (run)
         RUN_CLEAR: run_byte = clear_byte(idx);
         RUN_CSI: begin
            if (idx == RUN_IDX_W'(0)) run_byte = CHAR_ESC;
            else if (idx == RUN_IDX_W'(1)) run_byte = CHAR_LBR;
            else run_byte = value;
         end
         default:   run_byte = value;
      endcase
   endfunction

endpackage

// ===== rtl/pab_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module pab_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pab_front.sv =====
// front end: accepts items, decodes console codes, owns the byte queue and flags
// depends on pab_pkg and pab_ram
`timescale 1ns / 1ps

module pab_front import pab_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_push,
   output logic          req_full,
   input  logic [1:0]    req_op,
   input  logic [7:0]    req_data,
   input  fifo_status_type fifo_status,
   output logic          fifo_push,
   output run_entry_type fifo_entry
);

   logic              first_ff, first_in;
   logic              skip_ff, skip_in;
   logic [QPTR_W-1:0] rptr_ff, rptr_in;
   logic [QPTR_W-1:0] wptr_ff, wptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   logic              stage_valid_ff, stage_valid_in;
   logic              stage_mem_ff, stage_mem_in;
   run_type           stage_run_ff, stage_run_in;
   logic [7:0]        stage_value_ff, stage_value_in;

   logic              stage_adv;
   logic              accept;
   logic              run_ok;
   logic              ram_we;
   logic              ram_re;
   logic [7:0]        ram_rd_data;

   pab_ram #(
      .WIDTH (8),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wptr_ff),
      .wr_data (req_data),
      .rd_en   (ram_re),
      .rd_addr (rptr_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      first_in       = first_ff;
      skip_in        = skip_ff;
      rptr_in        = rptr_ff;
      wptr_in        = wptr_ff;
      count_in       = count_ff;
      stage_valid_in = stage_valid_ff;
      stage_mem_in   = stage_mem_ff;
      stage_run_in   = stage_run_ff;
      stage_value_in = stage_value_ff;
      ram_we         = 1'b0;
      ram_re         = 1'b0;
      run_ok         = 1'b0;

      stage_adv = !stage_valid_ff || !fifo_status.full;
      accept    = req_push && stage_adv;

      if (accept) begin
         stage_mem_in   = 1'b0;
         stage_run_in   = RUN_BYTE;
         stage_value_in = req_data;
         unique case (op_type'(req_op))
            OP_WRITE: begin
               if (req_data == CODE_CR) begin
                  if (skip_ff) begin
                     skip_in = 1'b0;
                  end else begin
                     run_ok         = 1'b1;
                     stage_value_in = CHAR_LF;
                  end
               end else if (req_data >= CODE_PRINT_LO && req_data <= CODE_PRINT_HI) begin
                  run_ok = 1'b1;
               end else begin
                  unique case (req_data)
                     CODE_LEFT: begin
                        run_ok = 1'b1; stage_run_in = RUN_CSI; stage_value_in = CHAR_D;
                     end
                     CODE_RIGHT: begin
                        run_ok = 1'b1; stage_run_in = RUN_CSI; stage_value_in = CHAR_C;
                     end
                     CODE_UP: begin
                        run_ok = 1'b1; stage_run_in = RUN_CSI; stage_value_in = CHAR_A;
                     end
                     CODE_DOWN: begin
                        run_ok = 1'b1; stage_run_in = RUN_CSI; stage_value_in = CHAR_B;
                     end
                     CODE_HOME: begin
                        run_ok = 1'b1; stage_run_in = RUN_CSI; stage_value_in = CHAR_H;
                     end
                     CODE_CLEAR: begin
                        if (first_ff) begin
                           first_in = 1'b0;
                        end else begin
                           run_ok       = 1'b1;
                           stage_run_in = RUN_CLEAR;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            OP_PUSH: begin
               // zero bytes and pushes into a full queue are dropped
               if (req_data != 8'h00 && count_ff != QCNT_W'(QUEUE_DEPTH)) begin
                  ram_we   = 1'b1;
                  wptr_in  = (wptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + QPTR_W'(1);
                  count_in = count_ff + QCNT_W'(1);
               end
            end
            OP_READ: begin
               run_ok       = 1'b1;
               stage_run_in = RUN_READ;
               if (count_ff == '0) begin
                  if (req_data == CODE_CR) begin
                     skip_in = 1'b1;
                  end
               end else begin
                  ram_re       = 1'b1;
                  stage_mem_in = 1'b1;
                  rptr_in  = (rptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + QPTR_W'(1);
                  count_in = count_ff - QCNT_W'(1);
               end
            end
            default: ;
         endcase
      end

      if (stage_adv) begin
         stage_valid_in = accept && run_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff       <= 1'b1;
         skip_ff        <= 1'b0;
         rptr_ff        <= '0;
         wptr_ff        <= '0;
         count_ff       <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         first_ff       <= first_in;
         skip_ff        <= skip_in;
         rptr_ff        <= rptr_in;
         wptr_ff        <= wptr_in;
         count_ff       <= count_in;
         stage_valid_ff <= stage_valid_in;
      end
      stage_mem_ff   <= stage_mem_in;
      stage_run_ff   <= stage_run_in;
      stage_value_ff <= stage_value_in;
   end

   assign req_full         = !stage_adv;
   assign fifo_push        = stage_valid_ff && !fifo_status.full;
   assign fifo_entry.run   = stage_run_ff;
   // queued bytes come from the ram read data register, loaded together with the stage
   assign fifo_entry.value = stage_mem_ff ? ram_rd_data : stage_value_ff;

endmodule

// ===== rtl/pab_run_fifo.sv =====
// small run queue that decouples the decode front end from the byte back end
// depends on pab_pkg
`timescale 1ns / 1ps

module pab_run_fifo import pab_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  run_entry_type   push_entry,
   input  logic            pop,
   output run_entry_type   head,
   output fifo_status_type status
);

   run_entry_type       mem_ff [RUN_FIFO_DEPTH];
   logic [RF_PTR_W-1:0] wptr_ff, wptr_in;
   logic [RF_PTR_W-1:0] rptr_ff, rptr_in;
   logic [RF_CNT_W-1:0] count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   always_comb begin
      do_push  = push && (count_ff != RF_CNT_W'(RUN_FIFO_DEPTH));
      do_pop   = pop && (count_ff != '0);
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == RF_PTR_W'(RUN_FIFO_DEPTH - 1)) ? '0 : wptr_ff + RF_PTR_W'(1);
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == RF_PTR_W'(RUN_FIFO_DEPTH - 1)) ? '0 : rptr_ff + RF_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + RF_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - RF_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         mem_ff[wptr_ff] <= push_entry;
      end
   end

   assign head         = mem_ff[rptr_ff];
   assign status.full  = (count_ff == RF_CNT_W'(RUN_FIFO_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

// ===== rtl/pab_back.sv =====
// back end: expands queued runs into single result bytes, one per cycle while results are popped
// depends on pab_pkg
`timescale 1ns / 1ps

module pab_back import pab_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  fifo_status_type fifo_status,
   input  run_entry_type   fifo_head,
   output logic            fifo_pop,
   output logic            rsp_empty,
   input  logic            rsp_pop,
   output logic            rsp_kind,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_last
);

   logic [RUN_IDX_W-1:0] idx_ff, idx_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 kind_ff, kind_in;
   logic [7:0]           byte_ff, byte_in;
   logic                 last_ff, last_in;
   logic                 slot_free;
   logic                 emit;
   logic                 is_last;

   always_comb begin
      slot_free = !out_valid_ff || rsp_pop;
      emit      = slot_free && !fifo_status.empty;
      is_last   = (idx_ff == run_last_idx(fifo_head.run));

      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      kind_in      = kind_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;

      if (emit) begin
         idx_in       = is_last ? '0 : idx_ff + RUN_IDX_W'(1);
         out_valid_in = 1'b1;
         kind_in      = (fifo_head.run == RUN_READ) ? KIND_READ : KIND_TX;
         byte_in      = run_byte(fifo_head.run, fifo_head.value, idx_ff);
         last_in      = is_last;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
      kind_ff <= kind_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign fifo_pop     = emit && is_last;
   assign rsp_empty    = !out_valid_ff;
   assign rsp_kind     = kind_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_last     = last_ff;

endmodule

// ===== rtl/petscii_to_ansi_console_bridge.sv =====
// top level of the console bridge: front end, run queue and back end
// depends on pab_pkg, pab_front, pab_run_fifo and pab_back
`timescale 1ns / 1ps

// Console bridge between an emulator and a serial terminal. Each input transfer carries
// an op and a data byte: op 0 writes a console code (carriage return becomes LF unless a
// typed CR was just read, printable ASCII passes through, cursor codes become ANSI
// ESC [ A/B/C/D/H, clear becomes ESC[2J ESC[H with the first clear after reset dropped,
// anything else is ignored); op 1 pushes a nonzero byte into a 256-entry input queue
// (dropped when full); op 2 reads the queue, or returns the carried typed byte when the
// queue is empty. Op 3 does nothing. Every result transfer carries kind (0 transmit byte,
// 1 read data), the byte, and last, set on the final byte of the run one item caused.
// Rate: one item is taken every clock as long as the back end keeps up; results leave at
// one byte per clock while rsp_pop takes them, and a write yields one result byte per
// byte of its run (three for a cursor code, seven for a clear); items that produce
// nothing take no result slot. The back end's single byte-per-cycle expansion sets
// sustained throughput; a four-entry run queue absorbs bursts, after which full rises.
// A first result passes the front stage register, the run queue and the output register.

module petscii_to_ansi_console_bridge import pab_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   // input channel
   input  logic       req_push,
   output logic       req_full,
   input  logic [1:0] req_op,
   input  logic [7:0] req_data,
   // result channel
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last
);

   // decoded runs travelling from front to back
   logic            front_push;
   run_entry_type   front_entry;
   logic            back_pop;
   run_entry_type   fifo_head;
   fifo_status_type fifo_status;

   // front end: decode, flags, input byte queue with its ram
   pab_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_op      (req_op),
      .req_data    (req_data),
      .fifo_status (fifo_status),
      .fifo_push   (front_push),
      .fifo_entry  (front_entry)
   );

   // run queue lets the front keep taking items while a long escape run drains
   pab_run_fifo u_run_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (front_push),
      .push_entry (front_entry),
      .pop        (back_pop),
      .head       (fifo_head),
      .status     (fifo_status)
   );

   // back end: one result byte per cycle into the output register while results are popped
   pab_back u_back (
      .clock        (clock),
      .reset        (reset),
      .fifo_status  (fifo_status),
      .fifo_head    (fifo_head),
      .fifo_pop     (back_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_kind     (rsp_kind),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule

// ===== rtl/pab_checker.sv =====
// port-level checks on the console bridge, bound to the top level
// depends on pab_pkg
`timescale 1ns / 1ps

module pab_checker import pab_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic       rsp_kind,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last
);

   // no result survives reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result waiting after reset");

   // the input side is open right after reset
   a_reset_open: assert property (@(posedge clock) reset |=> !req_full)
      else $error("input blocked after reset");

   // read data is always a one-byte run
   a_read_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind == KIND_READ) |-> rsp_last)
      else $error("read data without last");

   // an escape byte starts an escape sequence, it never ends a run
   a_esc_not_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind == KIND_TX && rsp_out_byte == CHAR_ESC) |-> !rsp_last)
      else $error("escape byte ends a run");

   // a result not taken stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_out_byte)
                                    && $stable(rsp_kind) && $stable(rsp_last)))
      else $error("waiting result changed");

endmodule

bind petscii_to_ansi_console_bridge pab_checker u_pab_checker (.*);
